// ----- sv/bti_pkg.sv -----
// Shared types, codes and constants of the breakpoint table interpolator.
package bti_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned LENGTH_W  = 11;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned IN_DATA_W = 112;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned STATUS_W  = 2;

  // interpolation datapath
  localparam int unsigned DIFF_W    = 33;
  localparam int unsigned MUL_SPLIT = 17;
  localparam int unsigned PP_W      = 50;
  localparam int unsigned PROD_W    = 66;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned DIV_STEPS = 33;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_BACKWARD = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_LINEAR   = 2'd2
  } interp_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXACT     = 2'd0,
    ST_INTERP    = 2'd1,
    ST_PAST_END  = 2'd2,
    ST_TOO_EARLY = 2'd3
  } status_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } item_kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_INTERP_MODE  = 1'b0,
    REG_TABLE_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    item_kind_t                 kind;
    logic [INDEX_W-1:0]         point_index;
    logic signed [TIME_W-1:0]   point_time;
    logic signed [VALUE_W-1:0]  point_value;
    logic signed [TIME_W-1:0]   query_time;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   result_value;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_DECIDE,
    S_FETCH,
    S_PREV,
    S_NEXT,
    S_CHECK,
    S_MULDIV,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL_LO,
    MD_MUL_HI,
    MD_SUM,
    MD_DIV
  } md_phase_t;

endpackage

// ----- sv/bti_muldiv.sv -----
// Sequential unit for floor(mag * dq / dt): split multiply, then restoring division.
module bti_muldiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bti_pkg::DIFF_W-1:0]  mag,
  input  logic [bti_pkg::DIFF_W-1:0]  dq,
  input  logic [bti_pkg::DIFF_W-1:0]  dt,
  output logic                        done,
  output logic [bti_pkg::DIFF_W-1:0]  quot
);
  import bti_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  md_phase_t phase, phase_next;

  logic [DIFF_W-1:0] a;
  logic [DIFF_W-1:0] b;
  logic [DIFF_W-1:0] dvs;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] acc;
  logic [DIFF_W-1:0] rem;
  logic [DIFF_W-1:0] qs;
  logic [CNT_W-1:0]  cnt;

  logic [PROD_W-1:0] sum;
  logic [DIFF_W:0]   trial;
  logic [DIFF_W:0]   diff;
  logic              last_step;

  assign sum       = acc + (PROD_W'(pp) << MUL_SPLIT);
  assign trial     = {rem, qs[DIFF_W-1]};
  assign diff      = trial - {1'b0, dvs};
  assign last_step = (cnt == CNT_W'(DIV_STEPS - 1));
  assign quot      = qs;

  always_comb begin
    phase_next = phase;
    case (phase)
      MD_IDLE:   if (start) phase_next = MD_MUL_LO;
      MD_MUL_LO: phase_next = MD_MUL_HI;
      MD_MUL_HI: phase_next = MD_SUM;
      MD_SUM:    phase_next = MD_DIV;
      MD_DIV:    if (last_step) phase_next = MD_IDLE;
      default:   phase_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == MD_DIV) && last_step;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      MD_IDLE: begin
        if (start) begin
          a   <= mag;
          b   <= dq;
          dvs <= dt;
        end
      end
      MD_MUL_LO: pp <= PP_W'(a) * PP_W'(b[MUL_SPLIT-1:0]);
      MD_MUL_HI: begin
        acc <= PROD_W'(pp);
        pp  <= PP_W'(a) * PP_W'(b[DIFF_W-1:MUL_SPLIT]);
      end
      MD_SUM: begin
        rem <= sum[PROD_W-1:DIFF_W];
        qs  <= sum[DIFF_W-1:0];
        cnt <= '0;
      end
      MD_DIV: begin
        if (!diff[DIFF_W]) begin
          rem <= diff[DIFF_W-1:0];
          qs  <= {qs[DIFF_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIFF_W-1:0];
          qs  <= {qs[DIFF_W-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    phase == MD_DIV |-> rem < dvs)
    else $error("partial remainder not below divisor");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (start && phase == MD_IDLE) |=> phase == MD_MUL_LO)
    else $error("start not taken by idle unit");

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(phase) == MD_DIV)
    else $error("done without division step");

endmodule

// ----- sv/bti_ctrl.sv -----
// Table memories and the search / interpolation sequencer.
module bti_ctrl #(
  parameter int unsigned TABLE_DEPTH = bti_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned LW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bti_pkg::item_t        item,
  input  bti_pkg::interp_mode_t interp_mode,
  input  logic [LW-1:0]         length,
  output logic                  res_valid,
  input  logic                  res_ready,
  output bti_pkg::result_t      res
);
  import bti_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic signed [TIME_W-1:0]  time_mem  [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] value_mem [TABLE_DEPTH];
  logic signed [TIME_W-1:0]  t_rdata;
  logic signed [VALUE_W-1:0] v_rdata;
  logic [AW-1:0]             t_raddr;
  logic [AW-1:0]             v_raddr;
  logic [AW-1:0]             waddr;
  logic                      mem_we;

  ctrl_state_t state, state_next;

  logic signed [TIME_W-1:0]  q;
  interp_mode_t              m;
  logic [LW-1:0]             len;
  logic [LW-1:0]             lo, lo_next;
  logic [LW-1:0]             hi, hi_next;
  logic signed [TIME_W-1:0]  t0;
  logic signed [VALUE_W-1:0] v0;
  logic signed [DIFF_W-1:0]  dt;
  logic signed [DIFF_W-1:0]  dq;
  logic signed [DIFF_W-1:0]  dv;
  result_t                   res_next;

  logic [LW:0]        mid_sum;
  logic [LW-1:0]      mid;
  logic [LW:0]        nx_sum;
  logic [LW-1:0]      nx_mid;
  logic [LW-1:0]      len_m1;
  logic               search_step;
  logic               go;
  logic [DIFF_W-1:0]  mag;
  logic               md_start;
  logic               md_done;
  logic [DIFF_W-1:0]  md_quot;
  logic [SUM_W-1:0]   lin_sum;
  logic [VALUE_W-1:0] lin_sat;

  assign waddr   = AW'(item.point_index);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[LW:1];
  assign len_m1  = len - LW'(1);
  assign mag     = dv[DIFF_W-1] ? DIFF_W'(-dv) : DIFF_W'(dv);

  assign lin_sum = dv[DIFF_W-1] ?
                   {{(SUM_W-VALUE_W){v0[VALUE_W-1]}}, v0} - {2'b00, md_quot} :
                   {{(SUM_W-VALUE_W){v0[VALUE_W-1]}}, v0} + {2'b00, md_quot};

  always_comb begin
    if (lin_sum[SUM_W-1:VALUE_W-1] == '0 || lin_sum[SUM_W-1:VALUE_W-1] == '1)
      lin_sat = lin_sum[VALUE_W-1:0];
    else if (lin_sum[SUM_W-1])
      lin_sat = VALUE_MIN;
    else
      lin_sat = VALUE_MAX;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[waddr]  <= item.point_time;
      value_mem[waddr] <= item.point_value;
    end
    t_rdata <= time_mem[t_raddr];
    v_rdata <= value_mem[v_raddr];
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    md_start    = 1'b0;
    t_raddr     = '0;
    v_raddr     = '0;
    lo_next     = lo;
    hi_next     = hi;
    res_next    = res;
    search_step = 1'b0;
    go          = 1'b0;
    nx_sum      = '0;
    nx_mid      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        lo_next  = '0;
        hi_next  = length;
        if (in_valid) begin
          if (item.kind == KIND_QUERY)
            state_next = S_FIRST;
          else
            mem_we = (32'(item.point_index) < TABLE_DEPTH);
        end
      end
      S_FIRST: begin
        t_raddr = len_m1[AW-1:0];
        if (q <= t_rdata)
          state_next = S_DECIDE;
        else
          state_next = S_LAST;
      end
      S_LAST: begin
        search_step = 1'b1;
        if (q >= t_rdata) begin
          lo_next = len_m1;
          hi_next = len;
        end
      end
      S_SEARCH: begin
        search_step = 1'b1;
        if (q < t_rdata)
          hi_next = mid;
        else
          lo_next = mid;
      end
      S_DECIDE: begin
        t_raddr = lo[AW-1:0];
        v_raddr = lo[AW-1:0];
        if (lo >= len_m1) begin
          res_next.result_value = '0;
          res_next.status       = ST_PAST_END;
          state_next            = S_FINISH;
        end else if (lo == '0 && m != MODE_FORWARD) begin
          res_next.result_value = '0;
          res_next.status       = ST_TOO_EARLY;
          state_next            = S_FINISH;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (q == t_rdata) begin
          res_next.result_value = v_rdata;
          res_next.status       = ST_EXACT;
          state_next            = S_FINISH;
        end else begin
          res_next.status = ST_INTERP;
          case (m)
            MODE_BACKWARD: begin
              v_raddr    = AW'(lo - LW'(1));
              state_next = S_PREV;
            end
            MODE_FORWARD: begin
              res_next.result_value = v_rdata;
              state_next            = S_FINISH;
            end
            default: begin
              t_raddr    = AW'(lo + LW'(1));
              v_raddr    = AW'(lo + LW'(1));
              state_next = S_NEXT;
            end
          endcase
        end
      end
      S_PREV: begin
        res_next.result_value = v_rdata;
        state_next            = S_FINISH;
      end
      S_NEXT: state_next = S_CHECK;
      S_CHECK: begin
        if (dt <= 0 || dq <= 0 || dq >= dt) begin
          res_next.result_value = v0;
          state_next            = S_FINISH;
        end else begin
          md_start   = 1'b1;
          state_next = S_MULDIV;
        end
      end
      S_MULDIV: begin
        if (md_done) begin
          res_next.result_value = lin_sat;
          state_next            = S_FINISH;
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready)
          state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (search_step) begin
      nx_sum = {1'b0, lo_next} + {1'b0, hi_next};
      nx_mid = nx_sum[LW:1];
      go     = ({1'b0, hi_next} > ({1'b0, lo_next} + (LW+1)'(1)));
      if (go) begin
        t_raddr    = nx_mid[AW-1:0];
        state_next = S_SEARCH;
      end else begin
        state_next = S_DECIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= S_IDLE;
    else
      state <= state_next;
  end

  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    res <= res_next;
    if (state == S_IDLE && in_valid) begin
      q   <= item.query_time;
      m   <= interp_mode;
      len <= length;
    end
    if (state == S_FETCH) begin
      t0 <= t_rdata;
      v0 <= v_rdata;
    end
    if (state == S_NEXT) begin
      dt <= {t_rdata[TIME_W-1], t_rdata} - {t0[TIME_W-1], t0};
      dq <= {q[TIME_W-1], q} - {t0[TIME_W-1], t0};
      dv <= {v_rdata[VALUE_W-1], v_rdata} - {v0[VALUE_W-1], v0};
    end
  end

  bti_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .mag   (mag),
    .dq    (DIFF_W'(dq)),
    .dt    (DIFF_W'(dt)),
    .done  (md_done),
    .quot  (md_quot)
  );

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> ({1'b0, hi} > ({1'b0, lo} + (LW+1)'(1))))
    else $error("search window collapsed while probing");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> lo < len)
    else $error("search index beyond table length");

  a_zero_at_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status == ST_PAST_END || res.status == ST_TOO_EARLY))
      |-> res.result_value == '0)
    else $error("end-of-table result not zero");

endmodule

// ----- sv/breakpoint_table_interpolator_unit.sv -----
// Top level: configuration registers, request unpacking and output register.
//
// A stream of requests enters on s_axis. tuser = 0 marks a load request that
// writes one breakpoint (time, value) at point_index and gives no result. tuser = 1
// marks a query whose result leaves on m_axis: tdata the Q16.16 value, tuser the
// status code.
// A query binary-searches the time table in a memory with one read port, one
// probe a cycle, then reads the neighboring entries. Backward mode adds a read
// of the previous value; linear queries that interpolate add a split multiply
// and a restoring division. One query is in flight at a time; the next request
// can be taken in the cycle after the result moves to the output register.
// Registers are written through cfg_we/cfg_addr/cfg_wdata, by the user only
// while idle; the block does not enforce this. Index 0 is the interpolation
// mode, index 1 the number of breakpoints in use. Reset sets linear mode and a
// length of 1; the tables are not cleared and must be loaded before queries.
// When m_axis stalls, the result waits in the output register and a new request
// is still taken and processed; it then holds until the register frees.
module breakpoint_table_interpolator_unit #(
  parameter int unsigned TABLE_DEPTH = bti_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_index[9:0], point_time[41:10], point_value[73:42], query_time[105:74]
  input  logic [bti_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind: 0 load, 1 query
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_value[31:0]
  output logic [bti_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [bti_pkg::STATUS_W-1:0]    m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [bti_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bti_pkg::LENGTH_W-1:0]    cfg_wdata
);
  import bti_pkg::*;

  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

  interp_mode_t        interp_mode;
  logic [LENGTH_W-1:0] table_length;
  logic [LW-1:0]       length;
  item_t               item;
  result_t             res;
  logic                res_valid;
  logic                res_ready;

  assign item.kind        = item_kind_t'(s_axis_tuser);
  assign item.point_index = s_axis_tdata[9:0];
  assign item.point_time  = s_axis_tdata[41:10];
  assign item.point_value = s_axis_tdata[73:42];
  assign item.query_time  = s_axis_tdata[105:74];

  always_comb begin
    if (table_length == '0)
      length = LW'(1);
    else if (32'(table_length) > TABLE_DEPTH)
      length = LW'(TABLE_DEPTH);
    else
      length = LW'(table_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode  <= MODE_LINEAR;
      table_length <= LENGTH_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_INTERP_MODE: begin
          case (cfg_wdata[MODE_W-1:0])
            MODE_BACKWARD: interp_mode <= MODE_BACKWARD;
            MODE_FORWARD:  interp_mode <= MODE_FORWARD;
            default:       interp_mode <= MODE_LINEAR;
          endcase
        end
        REG_TABLE_LENGTH: table_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst)
      m_axis_tvalid <= 1'b0;
    else if (res_ready)
      m_axis_tvalid <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= res.result_value;
      m_axis_tuser <= res.status;
    end
  end

  bti_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LW          (LW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .item        (item),
    .interp_mode (interp_mode),
    .length      (length),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

endmodule
